>>> rtl/core/burst_gated_rate_emitter_top_assert.svh
// Assertion macros for the burst gated rate emitter checker.
// Needs nothing else; included by the files that assert.
`ifndef BURST_GATED_RATE_EMITTER_TOP_ASSERT_SVH
`define BURST_GATED_RATE_EMITTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BGRE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BGRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bgre_pkg.sv
// Shared widths, register indexes and stream item types of the burst gated
// rate emitter. No dependencies.
package bgre_pkg;

    localparam int RATE_W    = 32;
    localparam int TIME_W    = 32;
    localparam int ELAPSED_W = 16;
    localparam int RAND_W    = 16;
    localparam int COUNT_W   = 16;

    localparam int ITEM_W    = RAND_W + 1 + ELAPSED_W;
    localparam int RESULT_W  = 1 + 1 + COUNT_W;
    localparam int S_TDATA_W = ((ITEM_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_EMISSION_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MAX    = 3'd4;

    localparam logic KIND_TICK       = 1'b0;
    localparam logic KIND_SET_ENABLE = 1'b1;

    typedef struct packed {
        logic [RAND_W-1:0]    rand_fraction;
        logic                 enable_value;
        logic [ELAPSED_W-1:0] elapsed;
    } item_t;

    typedef struct packed {
        logic               enabled;
        logic               count_saturated;
        logic [COUNT_W-1:0] emit_count;
    } result_t;

endpackage

>>> rtl/core/burst_gated_rate_emitter_top.sv
// Burst gated rate emitter: particle count per tick with on/off burst timers.
// Depends on bgre_pkg.
//
// Accepts one transaction per clock unless a result is stalled, and returns
// one result per transaction: an input register, then one update pass that
// runs the rate multiply, the duration or repeat compare and the timer reload
// multiply, into a result register. Sustained rate is one item per cycle
// when not stalled, set by the single update pass; the input register absorbs
// one extra transaction while the result waits. Configuration writes are
// always taken and should be issued only while no transaction is in flight.
module burst_gated_rate_emitter_top
    import bgre_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // elapsed[15:0], enable_value[16], rand_fraction[32:17], zero above
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind[0]
    input  logic [S_TUSER_W-1:0] s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // emit_count[15:0], count_saturated[16], enabled[17], zero above
    output logic [M_TDATA_W-1:0] m_tdata,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_wdata
);

    localparam int PROD_W      = RATE_W + ELAPSED_W;
    localparam int ACC_W       = ((PROD_W > FRAC_BITS) ? PROD_W : FRAC_BITS) + 1;
    localparam int WHOLE_W     = ACC_W - FRAC_BITS;
    localparam int SPAN_PROD_W = TIME_W + RAND_W;

    logic [RATE_W-1:0] emission_rate_reg;
    logic [TIME_W-1:0] duration_min_reg;
    logic [TIME_W-1:0] duration_max_reg;
    logic [TIME_W-1:0] repeat_min_reg;
    logic [TIME_W-1:0] repeat_max_reg;

    logic              dur_up_reg;
    logic [TIME_W-1:0] dur_span_reg;
    logic              rep_up_reg;
    logic [TIME_W-1:0] rep_span_reg;

    logic              in_valid_reg;
    logic              in_kind_reg;
    item_t             in_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           out_next;

    logic                 enable_reg;
    logic                 enable_next;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [FRAC_BITS-1:0] frac_next;
    logic [TIME_W-1:0]    on_left_reg;
    logic [TIME_W-1:0]    on_left_next;
    logic [TIME_W-1:0]    off_left_reg;
    logic [TIME_W-1:0]    off_left_next;

    logic                   out_load_ok;
    logic                   fire;
    logic [PROD_W-1:0]      prod;
    logic [ACC_W-1:0]       acc;
    logic [WHOLE_W-1:0]     whole;
    logic                   saturate;
    logic                   reload_on;
    logic                   reload_up;
    logic [TIME_W-1:0]      reload_base;
    logic [TIME_W-1:0]      reload_span;
    logic [SPAN_PROD_W-1:0] span_prod;
    logic [TIME_W-1:0]      reload_offset;
    logic [TIME_W-1:0]      reload_val;
    logic [TIME_W-1:0]      elapsed_ext;
    logic                   on_expired;
    logic                   off_expired;

    assign cfg_ready   = 1'b1;
    assign out_load_ok = !out_valid_reg || m_tready;
    assign s_tready    = !in_valid_reg || out_load_ok;
    assign fire        = in_valid_reg && out_load_ok;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = {(M_TDATA_W - RESULT_W)'(0), out_reg};

    always_comb begin
        prod     = PROD_W'(emission_rate_reg) * PROD_W'(in_reg.elapsed);
        acc      = ACC_W'(prod) + ACC_W'(frac_reg);
        whole    = acc[ACC_W-1:FRAC_BITS];
        saturate = |whole[WHOLE_W-1:COUNT_W];

        reload_on     = (in_kind_reg == KIND_SET_ENABLE) ? in_reg.enable_value : !enable_reg;
        reload_up     = reload_on ? dur_up_reg : rep_up_reg;
        reload_base   = reload_on ? duration_min_reg : repeat_min_reg;
        reload_span   = reload_on ? dur_span_reg : rep_span_reg;
        span_prod     = SPAN_PROD_W'(reload_span) * SPAN_PROD_W'(in_reg.rand_fraction);
        reload_offset = span_prod[SPAN_PROD_W-1:RAND_W];
        reload_val    = reload_up ? reload_base + reload_offset
                                  : reload_base - reload_offset;

        elapsed_ext = TIME_W'(in_reg.elapsed);
        on_expired  = on_left_reg <= elapsed_ext;
        off_expired = off_left_reg <= elapsed_ext;

        enable_next   = enable_reg;
        frac_next     = frac_reg;
        on_left_next  = on_left_reg;
        off_left_next = off_left_reg;
        out_next      = '0;

        if (in_kind_reg == KIND_SET_ENABLE) begin
            enable_next = in_reg.enable_value;
            if (in_reg.enable_value) begin
                on_left_next = reload_val;
            end else begin
                off_left_next = reload_val;
            end
        end else if (enable_reg) begin
            frac_next                = acc[FRAC_BITS-1:0];
            out_next.count_saturated = saturate;
            out_next.emit_count      = saturate ? {COUNT_W{1'b1}} : whole[COUNT_W-1:0];
            if (duration_max_reg != '0) begin
                if (on_expired) begin
                    on_left_next  = '0;
                    enable_next   = 1'b0;
                    off_left_next = reload_val;
                end else begin
                    on_left_next = on_left_reg - elapsed_ext;
                end
            end
        end else if (repeat_max_reg != '0) begin
            if (off_expired) begin
                off_left_next = '0;
                enable_next   = 1'b1;
                on_left_next  = reload_val;
            end else begin
                off_left_next = off_left_reg - elapsed_ext;
            end
        end

        out_next.enabled = enable_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emission_rate_reg <= '0;
            duration_min_reg  <= '0;
            duration_max_reg  <= '0;
            repeat_min_reg    <= '0;
            repeat_max_reg    <= '0;
            dur_up_reg        <= 1'b1;
            dur_span_reg      <= '0;
            rep_up_reg        <= 1'b1;
            rep_span_reg      <= '0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            enable_reg        <= 1'b1;
            frac_reg          <= '0;
            on_left_reg       <= '0;
            off_left_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_EMISSION_RATE: emission_rate_reg <= cfg_wdata;
                    CFG_DURATION_MIN:  duration_min_reg  <= cfg_wdata;
                    CFG_DURATION_MAX:  duration_max_reg  <= cfg_wdata;
                    CFG_REPEAT_MIN:    repeat_min_reg    <= cfg_wdata;
                    CFG_REPEAT_MAX:    repeat_max_reg    <= cfg_wdata;
                    default: ;
                endcase
            end

            dur_up_reg   <= duration_max_reg >= duration_min_reg;
            dur_span_reg <= (duration_max_reg >= duration_min_reg)
                          ? duration_max_reg - duration_min_reg
                          : duration_min_reg - duration_max_reg;
            rep_up_reg   <= repeat_max_reg >= repeat_min_reg;
            rep_span_reg <= (repeat_max_reg >= repeat_min_reg)
                          ? repeat_max_reg - repeat_min_reg
                          : repeat_min_reg - repeat_max_reg;

            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load_ok) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                enable_reg   <= enable_next;
                frac_reg     <= frac_next;
                on_left_reg  <= on_left_next;
                off_left_reg <= off_left_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg      <= item_t'(s_tdata[ITEM_W-1:0]);
            in_kind_reg <= s_tuser[0];
        end
        if (fire) begin
            out_reg <= out_next;
        end
    end

endmodule

>>> rtl/core/bgre_checker.sv
// Port-level checks for burst_gated_rate_emitter_top, attached by bind.
// Depends on bgre_pkg and burst_gated_rate_emitter_top_assert.svh.
`include "burst_gated_rate_emitter_top_assert.svh"

module bgre_checker
    import bgre_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `BGRE_ASSERT_NEXT(a_result_holds, aclk, aresetn,
        m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "stalled result transaction changed")

    `BGRE_ASSERT_IMPLIES(a_sat_is_max, aclk, aresetn,
        m_tvalid && m_tdata[COUNT_W], m_tdata[COUNT_W-1:0] == {COUNT_W{1'b1}},
        "saturated count is not at its maximum")

    `BGRE_ASSERT_IMPLIES(a_stall_only_when_full, aclk, aresetn,
        !s_tready, m_tvalid && !m_tready,
        "input stalled while the result side can advance")

endmodule

bind burst_gated_rate_emitter_top bgre_checker u_bgre_checker (.*);
